>>> rtl/ppac_pkg.sv
// Shared constants and control structs for the polygon perimeter/area block.
// No dependencies; imported by every module under rtl.
package ppac_pkg;

    localparam int COORD_BITS_DEF   = 16;
    localparam int MAX_VERTICES_DEF = 256;

    localparam int PERIM_W    = 25;
    localparam int AREA_W     = 32;
    localparam int AREA_ACC_W = 48;
    localparam int TOTAL_W    = 9;
    localparam int LANES      = 6;

    localparam logic [PERIM_W-1:0] PERIM_MAX = '1;

    typedef struct packed {
        logic load;
        logic step;
        logic msb;
    } t_mul_ctl;

    typedef struct packed {
        logic load;
        logic step;
    } t_root_ctl;

endpackage

>>> rtl/ppac_mul.sv
// Bit-serial signed shift-and-add multiplier, one multiplier bit per cycle while i_ctl.step is high.
// Depends on ppac_pkg for t_mul_ctl.
module ppac_mul
    import ppac_pkg::*;
#(
    parameter int W = COORD_BITS_DEF + 1
) (
    input  logic                  i_clk,
    input  t_mul_ctl              i_ctl,
    input  logic signed [W-1:0]   i_a,
    input  logic signed [W-1:0]   i_b,
    output logic signed [2*W-1:0] o_prod
);

    localparam int PW = 2 * W;

    logic signed [PW-1:0] r_acc;
    logic signed [PW-1:0] r_mcand;
    logic        [W-1:0]  r_mplier;
    logic signed [PW-1:0] addend;

    assign addend = r_mplier[0] ? r_mcand : '0;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_acc    <= '0;
            r_mcand  <= PW'(i_a);
            r_mplier <= i_b;
        end else if (i_ctl.step) begin
            // sign bit of the multiplier carries negative weight
            r_acc    <= i_ctl.msb ? (r_acc - addend) : (r_acc + addend);
            r_mcand  <= r_mcand <<< 1;
            r_mplier <= r_mplier >> 1;
        end
    end

    assign o_prod = r_acc;

endmodule

>>> rtl/ppac_root.sv
// Digit-by-digit integer square root, one root bit per cycle while i_ctl.step is high.
// Depends on ppac_pkg for t_root_ctl.
module ppac_root
    import ppac_pkg::*;
#(
    parameter int RW = COORD_BITS_DEF + 1
) (
    input  logic              i_clk,
    input  t_root_ctl         i_ctl,
    input  logic [2*RW-1:0]   i_radicand,
    output logic [RW-1:0]     o_root
);

    logic [2*RW-1:0] r_n;
    logic [RW:0]     r_rem;
    logic [RW-1:0]   r_root;
    logic [RW+2:0]   rem2;
    logic [RW+2:0]   trial;
    logic [RW+2:0]   diff;

    assign rem2  = {r_rem, r_n[2*RW-1 -: 2]};
    assign trial = {1'b0, r_root, 2'b01};
    assign diff  = rem2 - trial;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_n    <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (i_ctl.step) begin
            // bring down two radicand bits, keep the trial subtraction if it fits
            r_n <= r_n << 2;
            if (rem2 >= trial) begin
                r_rem  <= diff[RW:0];
                r_root <= {r_root[RW-2:0], 1'b1};
            end else begin
                r_rem  <= rem2[RW:0];
                r_root <= {r_root[RW-2:0], 1'b0};
            end
        end
    end

    assign o_root = r_root;

endmodule

>>> rtl/polygon_perimeter_area_convexity.sv
// Polygon perimeter, shoelace area and convexity over a stream of vertices.
// Each vertex runs the serial multipliers and then the serial square root, one bit per cycle each;
// o_stall stays high until the vertex is folded in, so the next vertex waits for it.
// The last vertex adds a closing pass; the result is then registered in S_OUT once the
// output register is free, and can wait in its output register.
// Synchronous active-low reset clears all sums, vertex history and the output valid.
module polygon_perimeter_area_convexity
    import ppac_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int COORD_BITS   = COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [COORD_BITS-1:0] i_vx,
    input  logic signed [COORD_BITS-1:0] i_vy,
    input  logic                         i_last_vertex,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [PERIM_W-1:0]           o_perimeter_len,
    output logic [AREA_W-1:0]            o_area_abs,
    output logic                         o_is_convex,
    output logic                         o_is_closed,
    output logic [TOTAL_W-1:0]           o_vertex_total
);

    localparam int W     = COORD_BITS + 1;
    localparam int PW    = 2 * W;
    localparam int RW    = W;
    localparam int TW    = PW + 1;
    localparam int CNT_W = $clog2(W);
    localparam int CW    = $clog2(MAX_VERTICES + 1);
    localparam int XW    = (PW + 1 > AREA_ACC_W) ? PW + 1 : AREA_ACC_W;
    localparam int PSW   = ((RW > PERIM_W) ? RW : PERIM_W) + 1;
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(W - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_MUL,
        S_SQLD,
        S_ROOT,
        S_ACC,
        S_OUT
    } t_state;

    t_state                  r_state, n_state;
    logic [CNT_W-1:0]        r_cnt;
    logic                    r_close;
    logic signed [COORD_BITS-1:0] r_x, r_y;
    logic signed [COORD_BITS-1:0] r_first_x, r_first_y;
    logic signed [COORD_BITS-1:0] r_prev_x, r_prev_y;
    logic signed [COORD_BITS-1:0] r_older_x, r_older_y;
    logic                    r_last;
    logic                    r_closed;
    logic [CW-1:0]           r_count;
    logic [PERIM_W-1:0]      r_perim;
    logic [AREA_ACC_W-1:0]   r_area_acc;
    logic [2:0]              r_flags;

    logic                    r_out_valid;
    logic [PERIM_W-1:0]      r_out_perim;
    logic [AREA_W-1:0]       r_out_area;
    logic                    r_out_convex;
    logic                    r_out_closed;
    logic [TOTAL_W-1:0]      r_out_total;

    logic                    accept;
    logic                    out_free;
    t_mul_ctl                mul_ctl;
    t_root_ctl               root_ctl;

    logic signed [W-1:0]     ex, ey, epx, epy, eox, eoy, efx, efy;
    logic signed [W-1:0]     dxe, dye;
    logic signed [W-1:0]     op_a [LANES];
    logic signed [W-1:0]     op_b [LANES];
    logic signed [PW-1:0]    prod [LANES];
    logic [PW-1:0]           radicand;
    logic [RW-1:0]           root;

    logic [PSW-1:0]          perim_sum;
    logic [PERIM_W-1:0]      perim_next;
    logic signed [XW-1:0]    term;
    logic [AREA_ACC_W-1:0]   area_next;
    logic signed [TW-1:0]    tri_c;
    logic                    tri_pos, tri_neg;
    logic                    seen_any, seen_two;
    logic [AREA_ACC_W-1:0]   area_mag;
    logic [AREA_ACC_W-2:0]   area_half;
    logic [AREA_W-1:0]       area_out;

    assign o_stall  = (r_state != S_IDLE);
    assign accept   = i_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_stall;

    assign mul_ctl.load  = (r_state == S_LOAD);
    assign mul_ctl.step  = (r_state == S_MUL);
    assign mul_ctl.msb   = (r_cnt == LAST_STEP);
    assign root_ctl.load = (r_state == S_SQLD);
    assign root_ctl.step = (r_state == S_ROOT);

    assign ex  = W'(r_x);
    assign ey  = W'(r_y);
    assign epx = W'(r_prev_x);
    assign epy = W'(r_prev_y);
    assign eox = W'(r_older_x);
    assign eoy = W'(r_older_y);
    assign efx = W'(r_first_x);
    assign efy = W'(r_first_y);

    // on the closing pass prev already holds the last vertex
    always_comb begin
        dxe = r_close ? (efx - epx) : (ex - epx);
        dye = r_close ? (efy - epy) : (ey - epy);
        op_a[0] = dxe;
        op_b[0] = dxe;
        op_a[1] = dye;
        op_b[1] = dye;
        op_a[2] = epx;
        op_b[2] = r_close ? efy : ey;
        op_a[3] = r_close ? efx : ex;
        op_b[3] = epy;
        op_a[4] = epx - eox;
        op_b[4] = ey - eoy;
        op_a[5] = epy - eoy;
        op_b[5] = ex - eox;
    end

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        ppac_mul #(
            .W (W)
        ) u_mul (
            .i_clk  (i_clk),
            .i_ctl  (mul_ctl),
            .i_a    (op_a[g]),
            .i_b    (op_b[g]),
            .o_prod (prod[g])
        );
    end

    assign radicand = prod[0] + prod[1];

    ppac_root #(
        .RW (RW)
    ) u_root (
        .i_clk      (i_clk),
        .i_ctl      (root_ctl),
        .i_radicand (radicand),
        .o_root     (root)
    );

    always_comb begin
        perim_sum  = PSW'(r_perim) + PSW'(root);
        perim_next = (perim_sum > PSW'(PERIM_MAX)) ? PERIM_MAX : perim_sum[PERIM_W-1:0];
        term       = XW'(prod[2]) - XW'(prod[3]);
        area_next  = r_area_acc + term[AREA_ACC_W-1:0];
        tri_c      = TW'(prod[4]) - TW'(prod[5]);
        tri_neg    = tri_c[TW-1];
        tri_pos    = !tri_c[TW-1] && (tri_c != '0);
        seen_any   = (r_count != '0);
        seen_two   = (r_count >= CW'(2));
        area_mag   = r_area_acc[AREA_ACC_W-1] ? (-r_area_acc) : r_area_acc;
        area_half  = area_mag[AREA_ACC_W-1:1];
        area_out   = (|area_half[AREA_ACC_W-2:AREA_W]) ? '1 : area_half[AREA_W-1:0];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_valid) n_state = S_LOAD;
            S_LOAD: n_state = S_MUL;
            S_MUL:  if (r_cnt == LAST_STEP) n_state = S_SQLD;
            S_SQLD: n_state = S_ROOT;
            S_ROOT: if (r_cnt == LAST_STEP) n_state = S_ACC;
            S_ACC: begin
                if (r_close) n_state = S_OUT;
                else if (r_last) n_state = S_LOAD;
                else n_state = S_IDLE;
            end
            S_OUT:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_close     <= 1'b0;
            r_last      <= 1'b0;
            r_count     <= '0;
            r_perim     <= '0;
            r_area_acc  <= '0;
            r_flags     <= '0;
            r_first_x   <= '0;
            r_first_y   <= '0;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_older_x   <= '0;
            r_older_y   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (r_state == S_MUL || r_state == S_ROOT) begin
                r_cnt <= (r_cnt == LAST_STEP) ? '0 : r_cnt + 1'b1;
            end else begin
                r_cnt <= '0;
            end

            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end

            if (accept) begin
                r_x      <= i_vx;
                r_y      <= i_vy;
                r_last   <= i_last_vertex;
                r_closed <= (r_count == '0) || (i_vx == r_first_x && i_vy == r_first_y);
                if (r_count == '0) begin
                    r_first_x <= i_vx;
                    r_first_y <= i_vy;
                end
            end

            if (r_state == S_ACC) begin
                if (r_close) begin
                    r_perim    <= perim_next;
                    r_area_acc <= area_next;
                end else begin
                    if (seen_any) begin
                        r_perim    <= perim_next;
                        r_area_acc <= area_next;
                    end
                    if (seen_two) begin
                        r_flags <= r_flags | {!tri_pos && !tri_neg, tri_neg, tri_pos};
                    end
                    if (r_count < CW'(MAX_VERTICES)) begin
                        r_count <= r_count + 1'b1;
                    end
                    r_older_x <= r_prev_x;
                    r_older_y <= r_prev_y;
                    r_prev_x  <= r_x;
                    r_prev_y  <= r_y;
                    r_close   <= r_last;
                end
            end

            // publish the result and drop all polygon state
            if (r_state == S_OUT && out_free) begin
                r_out_perim  <= r_perim;
                r_out_area   <= area_out;
                r_out_convex <= !r_flags[2] && !(r_flags[0] && r_flags[1]);
                r_out_closed <= r_closed;
                r_out_total  <= TOTAL_W'(r_count);
                r_close      <= 1'b0;
                r_last       <= 1'b0;
                r_count      <= '0;
                r_perim      <= '0;
                r_area_acc   <= '0;
                r_flags      <= '0;
                r_first_x    <= '0;
                r_first_y    <= '0;
                r_prev_x     <= '0;
                r_prev_y     <= '0;
                r_older_x    <= '0;
                r_older_y    <= '0;
            end
        end
    end

    assign o_valid         = r_out_valid;
    assign o_perimeter_len = r_out_perim;
    assign o_area_abs      = r_out_area;
    assign o_is_convex     = r_out_convex;
    assign o_is_closed     = r_out_closed;
    assign o_vertex_total  = r_out_total;

    a_result_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_OUT))
        else $error("result valid raised outside the output state");

    a_root_after_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQLD) |-> ($past(r_state == S_MUL) && $past(r_cnt) == LAST_STEP))
        else $error("square root loaded before the multiply finished");

    a_clear_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && out_free) |=>
            (r_count == '0 && r_area_acc == '0 && r_flags == '0 && r_perim == '0))
        else $error("polygon state not cleared after a result");

endmodule

>>> bench/tb_polygon_perimeter_area_convexity.sv
`timescale 1ns / 1ps
// Self-checking bench for polygon_perimeter_area_convexity: vertex requests in, shape results out.
// Depends on ppac_pkg for result widths; predicts perimeter, area and flags independently.
module tb_polygon_perimeter_area_convexity
    import ppac_pkg::*;
();

    localparam int CW = COORD_BITS_DEF;
    localparam int IDLE_PCT = 13;
    localparam int HALF_DIV = 2;
    localparam logic [2:0] SEEN_POS  = 3'b001;
    localparam logic [2:0] SEEN_NEG  = 3'b010;
    localparam logic [2:0] SEEN_ZERO = 3'b100;
    localparam longint unsigned AREA_SAT = 64'hFFFF_FFFF;
    localparam int FULL_SPAN = 32768;

    typedef struct packed {
        logic signed [CW-1:0] vx;
        logic signed [CW-1:0] vy;
        logic                 last_vertex;
        logic                 drain;
    } t_vertex_req;

    typedef struct packed {
        logic [PERIM_W-1:0] perimeter_len;
        logic [AREA_W-1:0]  area_abs;
        logic               is_convex;
        logic               is_closed;
        logic [TOTAL_W-1:0] vertex_total;
    } t_shape_res;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic signed [CW-1:0] i_vx = '0;
    logic signed [CW-1:0] i_vy = '0;
    logic                 i_last_vertex = 1'b0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic [PERIM_W-1:0]   o_perimeter_len;
    logic [AREA_W-1:0]    o_area_abs;
    logic                 o_is_convex;
    logic                 o_is_closed;
    logic [TOTAL_W-1:0]   o_vertex_total;

    polygon_perimeter_area_convexity dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_vx           (i_vx),
        .i_vy           (i_vy),
        .i_last_vertex  (i_last_vertex),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_perimeter_len(o_perimeter_len),
        .o_area_abs     (o_area_abs),
        .o_is_convex    (o_is_convex),
        .o_is_closed    (o_is_closed),
        .o_vertex_total (o_vertex_total)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    int cyc = 0;
    always @(posedge i_clk) cyc <= cyc + 1;
    wire steady_window = (cyc >= 3000) && (cyc < 9000);

    t_vertex_req pending_q[$];
    t_shape_res  shape_q[$];
    t_vertex_req cur_req;
    int          mismatch_count = 0;
    int          gen_items = 0;
    int          gen_results = 0;

    // predicted polygon state
    longint           vtx_first_x = 0, vtx_first_y = 0;
    longint           vtx_prev_x = 0, vtx_prev_y = 0;
    longint           vtx_older_x = 0, vtx_older_y = 0;
    int               vtx_count = 0;
    longint unsigned  perim_sum = 0;
    logic [AREA_ACC_W-1:0] shoelace_sum = '0;
    logic [2:0]       turn_seen = '0;

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned rem, root, b;
        rem = n;
        root = 0;
        b = 64'd1 << 62;
        while (b > rem) b >>= 2;
        while (b != 0) begin
            if (rem >= root + b) begin
                rem -= root + b;
                root = (root >> 1) + b;
            end else begin
                root >>= 1;
            end
            b >>= 2;
        end
        return root;
    endfunction

    task automatic add_side(input longint ax, ay, bx, by);
        longint dx, dy;
        dx = bx - ax;
        dy = by - ay;
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        perim_sum += int_sqrt(dx * dx + dy * dy);
        if (perim_sum > PERIM_MAX) perim_sum = PERIM_MAX;
    endtask

    task automatic add_shoelace(input longint ax, ay, bx, by);
        longint term;
        term = ax * by - bx * ay;
        shoelace_sum = shoelace_sum + term[AREA_ACC_W-1:0];
    endtask

    task automatic fold_vertex(input t_vertex_req v);
        longint x, y, c, s;
        longint unsigned mag;
        t_shape_res r;
        x = $signed(v.vx);
        y = $signed(v.vy);
        if (vtx_count == 0) begin
            vtx_first_x = x;
            vtx_first_y = y;
        end else begin
            add_side(vtx_prev_x, vtx_prev_y, x, y);
            add_shoelace(vtx_prev_x, vtx_prev_y, x, y);
            if (vtx_count >= 2) begin
                c = (vtx_prev_x - vtx_older_x) * (y - vtx_older_y)
                  - (vtx_prev_y - vtx_older_y) * (x - vtx_older_x);
                if (c > 0) turn_seen |= SEEN_POS;
                else if (c < 0) turn_seen |= SEEN_NEG;
                else turn_seen |= SEEN_ZERO;
            end
        end
        if (vtx_count < MAX_VERTICES_DEF) vtx_count++;
        vtx_older_x = vtx_prev_x;
        vtx_older_y = vtx_prev_y;
        vtx_prev_x = x;
        vtx_prev_y = y;
        if (v.last_vertex) begin
            add_side(x, y, vtx_first_x, vtx_first_y);
            add_shoelace(x, y, vtx_first_x, vtx_first_y);
            s = $signed(shoelace_sum);
            if (s < 0) s = -s;
            mag = s / HALF_DIV;
            if (mag > AREA_SAT) mag = AREA_SAT;
            r.perimeter_len = perim_sum[PERIM_W-1:0];
            r.area_abs      = mag[AREA_W-1:0];
            r.is_convex     = (turn_seen == 3'b000) || (turn_seen == SEEN_POS)
                           || (turn_seen == SEEN_NEG);
            r.is_closed     = (x == vtx_first_x) && (y == vtx_first_y);
            r.vertex_total  = vtx_count[TOTAL_W-1:0];
            shape_q = {shape_q, r};
            // start over for the next polygon
            vtx_first_x = 0; vtx_first_y = 0;
            vtx_prev_x = 0;  vtx_prev_y = 0;
            vtx_older_x = 0; vtx_older_y = 0;
            vtx_count = 0;
            perim_sum = 0;
            shoelace_sum = '0;
            turn_seen = '0;
        end
    endtask

    task automatic compare_field(input string name, input longint unsigned want,
                                 input longint unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // driver: load the next request once the current one is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) fold_vertex(cur_req);
            if (!i_valid || !o_stall) begin
                if (pending_q.size() != 0
                    && !(pending_q[0].drain && shape_q.size() != 0)
                    && (steady_window || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    cur_req = pending_q.pop_front();
                    i_vx          <= cur_req.vx;
                    i_vy          <= cur_req.vy;
                    i_last_vertex <= cur_req.last_vertex;
                    i_valid       <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: check each taken result against the oldest prediction
    always @(posedge i_clk) begin
        t_shape_res w;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (shape_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual perimeter %0d area %0d",
                             $time, o_perimeter_len, o_area_abs);
                    mismatch_count++;
                end else begin
                    w = shape_q.pop_front();
                    compare_field("perimeter_len", w.perimeter_len, o_perimeter_len);
                    compare_field("area_abs", w.area_abs, o_area_abs);
                    compare_field("is_convex", w.is_convex, o_is_convex);
                    compare_field("is_closed", w.is_closed, o_is_closed);
                    compare_field("vertex_total", w.vertex_total, o_vertex_total);
                end
            end
            i_stall <= !steady_window && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    task automatic queue_vertex(input int x, input int y, input bit last_v, input bit hold);
        t_vertex_req v;
        v.vx = CW'(x);
        v.vy = CW'(y);
        v.last_vertex = last_v;
        v.drain = hold;
        pending_q = {pending_q, v};
        gen_items++;
        if (last_v) gen_results++;
    endtask

    function automatic int pick_coord(input int span);
        logic [CW-1:0] raw;
        raw = CW'($urandom);
        if (span >= FULL_SPAN) return int'($signed(raw));
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    task automatic queue_random_polygon();
        int xs[$], ys[$];
        int kind, n, cx, cy, hx, hy, span, dx, dy, k, step;
        bit hold;
        hold = ($urandom_range(0, 99) < 6);
        kind = $urandom_range(0, 9);
        cx = int'($urandom_range(0, 32000)) - 16000;
        cy = int'($urandom_range(0, 32000)) - 16000;
        case (kind)
            0, 1: begin
                hx = $urandom_range(1, 16000);
                hy = $urandom_range(1, 16000);
                xs = '{cx - hx, cx + hx, cx + hx, cx - hx};
                ys = '{cy - hy, cy - hy, cy + hy, cy + hy};
                if ($urandom_range(0, 1)) begin
                    xs.reverse();
                    ys.reverse();
                end
                if ($urandom_range(0, 3) == 0) begin
                    xs = {xs, xs[0]};
                    ys = {ys, ys[0]};
                end
            end
            2: begin
                hx = $urandom_range(1, 16000);
                xs = '{cx + hx, cx, cx - hx, cx};
                ys = '{cy, cy + hx, cy, cy - hx};
            end
            3: begin
                span = $urandom_range(0, 1) ? 255 : 4095;
                for (k = 0; k < 3; k++) begin
                    xs = {xs, pick_coord(span)};
                    ys = {ys, pick_coord(span)};
                end
            end
            4, 5: begin
                n = $urandom_range(1, 8);
                case ($urandom_range(0, 3))
                    0: span = 15;
                    1: span = 255;
                    2: span = 4095;
                    default: span = FULL_SPAN;
                endcase
                for (k = 0; k < n; k++) begin
                    xs = {xs, pick_coord(span)};
                    ys = {ys, pick_coord(span)};
                end
            end
            6: begin
                n = $urandom_range(3, 6);
                for (k = 0; k < n; k++) begin
                    xs = {xs, pick_coord(FULL_SPAN)};
                    ys = {ys, pick_coord(FULL_SPAN)};
                end
                xs = {xs, xs[0]};
                ys = {ys, ys[0]};
            end
            7: begin
                // points on one line, some repeated
                n = $urandom_range(3, 6);
                dx = int'($urandom_range(0, 200)) - 100;
                dy = int'($urandom_range(0, 200)) - 100;
                step = 0;
                for (k = 0; k < n; k++) begin
                    xs = {xs, cx + step * dx};
                    ys = {ys, cy + step * dy};
                    if ($urandom_range(0, 2) != 0) step++;
                end
            end
            default: begin
                n = kind - 7;
                for (k = 0; k < n; k++) begin
                    xs = {xs, pick_coord(FULL_SPAN)};
                    ys = {ys, pick_coord(FULL_SPAN)};
                end
            end
        endcase
        for (k = 0; k < xs.size(); k++)
            queue_vertex(xs[k], ys[k], k == xs.size() - 1, hold && k == 0);
    endtask

    initial begin
        int k;
        bit long_done;
        // single vertex
        queue_vertex(100, -200, 1'b1, 1'b0);
        // two vertices, the origin and an extreme corner
        queue_vertex(0, 0, 1'b0, 1'b0);
        queue_vertex(32767, -32768, 1'b1, 1'b0);
        // triangles, both turning directions
        queue_vertex(0, 0, 1'b0, 1'b0);
        queue_vertex(160, 0, 1'b0, 1'b0);
        queue_vertex(0, 160, 1'b1, 1'b0);
        queue_vertex(0, 0, 1'b0, 1'b0);
        queue_vertex(0, 160, 1'b0, 1'b0);
        queue_vertex(160, 0, 1'b1, 1'b0);
        // collinear triple
        queue_vertex(0, 0, 1'b0, 1'b0);
        queue_vertex(16, 16, 1'b0, 1'b0);
        queue_vertex(32, 32, 1'b1, 1'b0);
        // full-range square, then the same square wound twice to saturate the area
        for (k = 0; k < 12; k++)
            queue_vertex((k % 4 == 1 || k % 4 == 2) ? 32767 : -32768,
                         (k % 4 >= 2) ? 32767 : -32768,
                         k == 3 || k == 11, k == 4);

        long_done = 0;
        while (gen_items < 550 || gen_results < 60) begin
            if (!long_done && gen_items >= 120) begin
                // long zigzag: saturates both the perimeter and the vertex count
                for (k = 0; k < 370; k++)
                    queue_vertex(k[0] ? 32767 : -32768, k[0] ? 32767 : -32768,
                                 k == 369, k == 0);
                long_done = 1;
            end else begin
                queue_random_polygon();
            end
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(posedge i_clk); while (pending_q.size() != 0 || i_valid);
        do @(posedge i_clk); while (shape_q.size() != 0);
        repeat (200) @(posedge i_clk);

        if (mismatch_count == 0 && shape_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
